/* hdl/dbcm_pkg.sv */
`timescale 1ns / 1ps

package dbcm_pkg;

  localparam int RoundsDefault = 16;
  localparam int KeyIdxW       = 4;
  localparam int KeyW          = 48;
  localparam int BlockW        = 64;
  localparam int HalfW         = 32;
  localparam int ModeW         = 3;
  localparam int CfgIdxW       = 1;
  localparam int InUserW       = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CHAIN_MODE  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_VECTOR = 1'b1;

  // chaining modes; codes 6 and 7 fall back to ECB
  localparam logic [ModeW-1:0] MODE_ECB  = 3'd0;
  localparam logic [ModeW-1:0] MODE_CBC  = 3'd1;
  localparam logic [ModeW-1:0] MODE_PCBC = 3'd2;
  localparam logic [ModeW-1:0] MODE_CFB  = 3'd3;
  localparam logic [ModeW-1:0] MODE_OFB  = 3'd4;
  localparam logic [ModeW-1:0] MODE_CTR  = 3'd5;

  // input word kind
  localparam logic ITEM_DATA   = 1'b0;
  localparam logic ITEM_SUBKEY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } dbcm_state_t;

  typedef struct packed {
    logic               start;     // latch a data word and apply IP
    logic               round;     // run one Feistel round
    logic               finish;    // apply IP inverse, chain, fill output
    logic               key_wr;    // write one subkey
    logic [KeyIdxW-1:0] round_idx; // subkey used by this round
  } dbcm_cmd_t;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] IP_INV_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  // tables count bits from 1 at the MSB
  function automatic logic [BlockW-1:0] perm_ip(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] r;
    logic [5:0]        src;
    for (int i = 0; i < BlockW; i++) begin
      src = 6'(BlockW - int'(IP_TAB[i]));
      r[BlockW-1-i] = x[src];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] perm_ip_inv(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] r;
    logic [5:0]        src;
    for (int i = 0; i < BlockW; i++) begin
      src = 6'(BlockW - int'(IP_INV_TAB[i]));
      r[BlockW-1-i] = x[src];
    end
    return r;
  endfunction

  function automatic logic [HalfW-1:0] feistel(input logic [HalfW-1:0] rh,
                                               input logic [KeyW-1:0]  key);
    logic [KeyW-1:0]  x;
    logic [HalfW-1:0] s;
    logic [HalfW-1:0] p;
    logic [5:0]       b;
    logic [4:0]       src;
    for (int i = 0; i < KeyW; i++) begin
      src = 5'(HalfW - int'(E_TAB[i]));
      x[KeyW-1-i] = rh[src];
    end
    x = x ^ key;
    for (int i = 0; i < 8; i++) begin
      b = x[KeyW-1-6*i -: 6];
      s[HalfW-1-4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < HalfW; i++) begin
      src = 5'(HalfW - int'(P_TAB[i]));
      p[HalfW-1-i] = s[src];
    end
    return p;
  endfunction

endpackage

/* hdl/dbcm_ctrl.sv */
`timescale 1ns / 1ps

module dbcm_ctrl
  import dbcm_pkg::*;
#(
  parameter int ROUNDS = RoundsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_kind,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output dbcm_cmd_t cmd
);

  localparam int CntW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CntW-1:0] LastRound = CntW'(ROUNDS - 1);

  dbcm_state_t     state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.round_idx = KeyIdxW'(cnt_r);
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == ITEM_SUBKEY) begin
            cmd.key_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (cnt_r == LastRound) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hdl/dbcm_datapath.sv */
`timescale 1ns / 1ps

module dbcm_datapath
  import dbcm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dbcm_cmd_t           cmd,
  input  logic [BlockW-1:0]   in_tdata,
  input  logic [InUserW-1:0]  in_tuser,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [BlockW-1:0]   cfg_wdata,
  output logic [BlockW-1:0]   out_tdata
);

  logic [KeyW-1:0]   key_mem [16];
  logic [ModeW-1:0]  chain_mode_r;
  logic [BlockW-1:0] init_vector_r;
  logic [BlockW-1:0] chain_r, chain_nxt;
  logic [BlockW-1:0] plain_r;
  logic [HalfW-1:0]  left_r, right_r;
  logic [BlockW-1:0] out_r;

  logic [KeyIdxW-1:0] key_idx;
  logic               first_blk;
  logic [BlockW-1:0]  chain_in;
  logic [BlockW-1:0]  cipher_in;
  logic [BlockW-1:0]  ip_out;
  logic [BlockW-1:0]  enc_out;
  logic [BlockW-1:0]  cipher;

  assign key_idx   = in_tuser[KeyIdxW:1];
  assign first_blk = in_tuser[KeyIdxW+1];
  assign chain_in  = first_blk ? init_vector_r : chain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_mode_r  <= MODE_ECB;
      init_vector_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHAIN_MODE:  chain_mode_r  <= cfg_wdata[ModeW-1:0];
        CFG_INIT_VECTOR: init_vector_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[key_idx] <= in_tdata[KeyW-1:0];
    end
  end

  // block fed to the cipher
  always_comb begin
    case (chain_mode_r)
      MODE_CBC, MODE_PCBC:         cipher_in = in_tdata ^ chain_in;
      MODE_CFB, MODE_OFB, MODE_CTR: cipher_in = chain_in;
      default:                     cipher_in = in_tdata;
    endcase
  end

  assign ip_out  = perm_ip(cipher_in);
  assign enc_out = perm_ip_inv({right_r, left_r});

  always_comb begin
    case (chain_mode_r)
      MODE_CFB, MODE_OFB, MODE_CTR: cipher = enc_out ^ plain_r;
      default:                     cipher = enc_out;
    endcase
  end

  always_comb begin
    chain_nxt = chain_r;
    if (cmd.start) begin
      chain_nxt = chain_in;
    end else if (cmd.finish) begin
      case (chain_mode_r)
        MODE_CBC, MODE_CFB: chain_nxt = cipher;
        MODE_PCBC:          chain_nxt = plain_r ^ cipher;
        MODE_OFB:           chain_nxt = enc_out;
        MODE_CTR:           chain_nxt = chain_r + 64'd1;
        default:            chain_nxt = chain_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      plain_r <= in_tdata;
      left_r  <= ip_out[BlockW-1:HalfW];
      right_r <= ip_out[HalfW-1:0];
    end else if (cmd.round) begin
      left_r  <= right_r;
      right_r <= left_r ^ feistel(right_r, key_mem[cmd.round_idx]);
    end
    if (cmd.finish) begin
      out_r <= cipher;
    end
  end

  assign out_tdata = out_r;

endmodule

/* hdl/des_block_cipher_modes_core.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// in_      | slave     | tdata[63:0] data_in; tuser {first_block, subkey_index, kind}
// out_     | master    | tdata[63:0] out_block
// cfg_     | write     | index 0 chain_mode, 1 init_vector
//
// A data word is loaded through IP, runs its Feistel rounds one after another
// on the shared round unit, and is then chained into the output register. A
// subkey word yields no result. A new word is taken while a result waits.
// Reset (rst_n, synchronous) clears the mode, IV and chain value; subkeys
// stay undefined until loaded. A stalled output holds the block in its last
// step.

module des_block_cipher_modes_core
  import dbcm_pkg::*;
#(
  parameter int ROUNDS = RoundsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [BlockW-1:0]  in_tdata,   // [63:0] data_in
  input  logic [InUserW-1:0] in_tuser,   // [0] kind, [4:1] subkey_index, [5] first_block
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [BlockW-1:0]  out_tdata,  // [63:0] out_block
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [BlockW-1:0]  cfg_wdata
);

  dbcm_cmd_t cmd;

  // sequence the load, the rounds and the output handoff
  dbcm_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // hold subkeys, chain value, round halves and the result word
  dbcm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule

/* dv/des_cipher_checker.sv */
`timescale 1ns / 1ps

// Watches the in_, out_ and cfg_ ports of the DES chaining core, predicts every
// ciphertext block and compares the out_ words with the predictions in order.
module des_cipher_checker
  import dbcm_pkg::*;
#(
  parameter int ROUNDS = RoundsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [BlockW-1:0]  in_tdata,   // [63:0] data_in
  input  logic [InUserW-1:0] in_tuser,   // [0] kind, [4:1] subkey_index, [5] first_block
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [BlockW-1:0]  out_tdata,  // [63:0] out_block
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [BlockW-1:0]  cfg_wdata,
  output int                 mismatches,
  output int                 blocks_pending,
  output int                 blocks_checked
);

  localparam int INIT_PERM [64] = '{
    58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
    62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
    57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
    61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7
  };

  localparam int FINAL_PERM [64] = '{
    40, 8, 48, 16, 56, 24, 64, 32, 39, 7, 47, 15, 55, 23, 63, 31,
    38, 6, 46, 14, 54, 22, 62, 30, 37, 5, 45, 13, 53, 21, 61, 29,
    36, 4, 44, 12, 52, 20, 60, 28, 35, 3, 43, 11, 51, 19, 59, 27,
    34, 2, 42, 10, 50, 18, 58, 26, 33, 1, 41, 9, 49, 17, 57, 25
  };

  localparam int EXPAND [48] = '{
    32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
    8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
    16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
    24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
  };

  localparam int PBOX [32] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
  };

  localparam int S_TABLE [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
  };

  logic [KeyW-1:0]   round_keys [16];
  logic [BlockW-1:0] chain_reg;
  logic [BlockW-1:0] iv_reg;
  logic [ModeW-1:0]  mode_reg;
  logic [BlockW-1:0] cipher_q [$];

  logic [BlockW-1:0] plain;
  logic [BlockW-1:0] cipher;
  logic [BlockW-1:0] keystream;
  logic [BlockW-1:0] want;
  int                miss_cnt;
  int                check_cnt;

  // one block through IP, ROUNDS Feistel rounds, half swap and IP inverse
  function automatic logic [BlockW-1:0] encrypt_block(input logic [BlockW-1:0] blk);
    logic [BlockW-1:0] x;
    logic [BlockW-1:0] y;
    logic [HalfW-1:0]  lh;
    logic [HalfW-1:0]  rh;
    logic [HalfW-1:0]  t;
    logic [HalfW-1:0]  sv;
    logic [HalfW-1:0]  fv;
    logic [KeyW-1:0]   ex;
    logic [5:0]        b;
    for (int i = 0; i < 64; i++) x[63-i] = blk[64-INIT_PERM[i]];
    lh = x[63:32];
    rh = x[31:0];
    for (int r = 0; r < ROUNDS; r++) begin
      for (int i = 0; i < 48; i++) ex[47-i] = rh[32-EXPAND[i]];
      ex = ex ^ round_keys[r % 16];
      for (int i = 0; i < 8; i++) begin
        b = ex[47-6*i -: 6];
        sv[31-4*i -: 4] = 4'(S_TABLE[i][{b[5], b[0], b[4:1]}]);
      end
      for (int i = 0; i < 32; i++) fv[31-i] = sv[32-PBOX[i]];
      t  = lh;
      lh = rh;
      rh = t ^ fv;
    end
    x = {rh, lh};
    for (int i = 0; i < 64; i++) y[63-i] = x[64-FINAL_PERM[i]];
    return y;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_reg = '0;
      iv_reg    = '0;
      mode_reg  = MODE_ECB;
      cipher_q.delete();
      miss_cnt  = 0;
      check_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAIN_MODE:  mode_reg = cfg_wdata[ModeW-1:0];
          CFG_INIT_VECTOR: iv_reg = cfg_wdata;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        plain = in_tdata;
        if (in_tuser[0] == ITEM_SUBKEY) begin
          // drop the upper 16 bits; no result, chain untouched
          round_keys[in_tuser[4:1]] = plain[KeyW-1:0];
        end else begin
          if (in_tuser[5]) chain_reg = iv_reg;
          case (mode_reg)
            MODE_CBC: begin
              cipher    = encrypt_block(plain ^ chain_reg);
              chain_reg = cipher;
            end
            MODE_PCBC: begin
              cipher    = encrypt_block(plain ^ chain_reg);
              chain_reg = plain ^ cipher;
            end
            MODE_CFB: begin
              cipher    = encrypt_block(chain_reg) ^ plain;
              chain_reg = cipher;
            end
            MODE_OFB: begin
              keystream = encrypt_block(chain_reg);
              cipher    = keystream ^ plain;
              chain_reg = keystream;
            end
            MODE_CTR: begin
              cipher    = encrypt_block(chain_reg) ^ plain;
              chain_reg = chain_reg + 64'd1;
            end
            default: cipher = encrypt_block(plain);
          endcase
          cipher_q.push_back(cipher);
        end
      end

      if (out_tvalid && out_tready) begin
        if (cipher_q.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("%t unexpected out word %h, nothing pending", $realtime, out_tdata);
        end else begin
          want = cipher_q.pop_front();
          check_cnt++;
          if (out_tdata !== want) begin
            miss_cnt++;
            if (miss_cnt <= 10)
              $display("%t out_block mismatch on result %0d: expected %h, got %h",
                       $realtime, check_cnt, want, out_tdata);
          end
        end
      end
    end
    mismatches     <= miss_cnt;
    blocks_pending <= cipher_q.size();
    blocks_checked <= check_cnt;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

// Top of the DES chaining-core bench. This module only drives words, register
// writes and out_tready and gives the verdict; des_cipher_checker does all the
// prediction and comparison.
module tb;
  import dbcm_pkg::*;

  localparam int ROUNDS = RoundsDefault;

  // the two mode codes with no chaining of their own; they fall back to ECB
  localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;

  localparam logic [BlockW-1:0] ALL_ONES = '1;

  // data words per random segment and number of segments; with the subkey
  // words mixed in this comes to about 1300 input words
  localparam int SEG_WORDS = 92;
  localparam int SEG_COUNT = 12;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [BlockW-1:0]  in_tdata   = '0;   // [63:0] data_in
  logic [InUserW-1:0] in_tuser   = '0;   // [0] kind, [4:1] subkey_index, [5] first_block
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [BlockW-1:0]  out_tdata;         // [63:0] out_block
  logic               cfg_we     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [BlockW-1:0]  cfg_wdata  = '0;

  int mismatches;
  int blocks_pending;
  int blocks_checked;

  // idle percentages of the sender and the receiver, changed per phase
  int send_idle = 26;
  int recv_idle = 66;

  int data_words;
  int key_words;
  int settings;

  des_block_cipher_modes_core #(.ROUNDS(ROUNDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  des_cipher_checker #(.ROUNDS(ROUNDS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .blocks_pending (blocks_pending),
    .blocks_checked (blocks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drop tready at random, one decision per edge.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Random 64-bit value, with zero and all-ones now and then.
  function automatic logic [BlockW-1:0] rand_block();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  // Offer one word and hold it until the edge that accepts it. tvalid stays
  // high on return so that back-to-back words are offered without a gap; drop it
  // with end_stream once a run of words is over.
  task automatic push_word(input logic kind, input logic [KeyIdxW-1:0] idx,
                           input logic first, input logic [BlockW-1:0] data);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= {first, idx, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == ITEM_SUBKEY) key_words++;
    else data_words++;
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted block has come out, then give a trailing
  // subkey word or a stalled round the time a data word needs.
  task automatic settle();
    end_stream();
    while (blocks_pending != 0) @(posedge clk);
    repeat (2 * ROUNDS + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [BlockW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Change the chaining setup; only ever called with the core idle.
  task automatic set_chain(input logic [ModeW-1:0] mode, input logic [BlockW-1:0] iv);
    settle();
    write_reg(CFG_CHAIN_MODE, BlockW'(mode));
    write_reg(CFG_INIT_VECTOR, iv);
    settings++;
  endtask

  // Reload all sixteen round keys; upper data bits and first_block are noise.
  task automatic load_keys();
    for (int k = 0; k < 16; k++)
      push_word(ITEM_SUBKEY, KeyIdxW'(k), 1'($urandom_range(1)), rand_block());
  endtask

  logic [ModeW-1:0]  mode_plan [8];
  logic [BlockW-1:0] seg_iv;
  int                seg_done;
  int                pick;
  int                run_len;

  initial begin
    mode_plan = '{MODE_ECB, MODE_CBC, MODE_PCBC, MODE_CFB,
                  MODE_OFB, MODE_CTR, MODE_SPARE_LO, MODE_SPARE_HI};
    data_words = 0;
    key_words  = 0;
    settings   = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ---------------- directed part ----------------
    // Every round key is written before any data word reads it. Key 0 is
    // all zeros with first_block set; key 15 is all ones, upper bits too.
    push_word(ITEM_SUBKEY, KeyIdxW'(0), 1'b1, '0);
    for (int k = 1; k < 15; k++)
      push_word(ITEM_SUBKEY, KeyIdxW'(k), 1'($urandom_range(1)), {$urandom, $urandom});
    push_word(ITEM_SUBKEY, KeyIdxW'(15), 1'b0, ALL_ONES);

    // ECB straight out of reset, extreme plaintexts.
    push_word(ITEM_DATA, '0, 1'b1, '0);
    push_word(ITEM_DATA, '0, 1'b0, ALL_ONES);

    // A first block and a chained block in each real chaining mode. CTR starts
    // at all ones so that its counter wraps to zero on the second block.
    for (int m = 1; m <= 5; m++) begin
      set_chain(mode_plan[m], (m == 5) ? ALL_ONES :
                              (m % 2 == 1) ? '0 : {$urandom, $urandom});
      push_word(ITEM_DATA, '0, 1'b1, {$urandom, $urandom});
      push_word(ITEM_DATA, '0, 1'b0, {$urandom, $urandom});
    end

    // Highest unused mode code must act as ECB.
    set_chain(MODE_SPARE_HI, '0);
    push_word(ITEM_DATA, '0, 1'b1, {$urandom, $urandom});

    // ---------------- random part ----------------
    // Phases of idling: sender light and receiver heavy, then the reverse,
    // then full rate. Each segment picks a new mode and IV; the first eight
    // walk all mode codes, later ones pick at random.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      settle();
      if (seg == SEG_COUNT / 3) begin
        send_idle = 66;
        recv_idle = 26;
      end else if (seg == 2 * SEG_COUNT / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      pick = $urandom_range(3);
      seg_iv = (pick == 0) ? '0 : (pick == 1) ? ALL_ONES : {$urandom, $urandom};
      set_chain((seg < 8) ? mode_plan[seg] : mode_plan[$urandom_range(7)], seg_iv);

      seg_done = 0;
      while (seg_done < SEG_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          load_keys();
        end else if (pick < 12) begin
          // stray single key rewrite
          push_word(ITEM_SUBKEY, KeyIdxW'($urandom_range(15)),
                    1'($urandom_range(1)), rand_block());
        end else if (pick < 20) begin
          // noise: data word with a random first flag
          push_word(ITEM_DATA, KeyIdxW'($urandom_range(15)),
                    1'($urandom_range(1)), rand_block());
          seg_done++;
        end else begin
          // well-formed message: restart the chain, then chained blocks
          run_len = $urandom_range(12, 1);
          for (int w = 0; w < run_len; w++)
            push_word(ITEM_DATA, KeyIdxW'($urandom_range(15)), (w == 0), rand_block());
          seg_done += run_len;
        end
      end
    end

    settle();
    $display("covered %0d data words and %0d subkey words over %0d mode/IV settings",
             data_words, key_words, settings);
    $display("checked %0d cipher blocks, %0d mismatches", blocks_checked, mismatches);
    if (mismatches == 0 && blocks_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout with %0d blocks still pending", blocks_pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
